// ===== rtl/core/tmhd_pkg.sv =====
// Shared types, constants and the reciprocal table of the torus hop distance unit.
// Depends on nothing; imported by both design modules, the checker and the test.
`default_nettype none

package tmhd_pkg;

  // Geometry limits
  localparam int unsigned NumDims    = 4;
  localparam int unsigned MaxDims    = 4;
  localparam int unsigned MaxExtent  = 64;
  localparam int unsigned SwW        = 24;
  localparam int unsigned ExtW       = 7;
  localparam int unsigned HopW       = 6;
  localparam int unsigned TotW       = 8;
  localparam int unsigned NdW        = 3;
  localparam int unsigned RecipW     = 32;
  localparam int unsigned RecipShift = 31;
  localparam int unsigned ProdW      = SwW + RecipW;
  localparam int unsigned StageLat   = 3;
  localparam int unsigned Latency    = NumDims * StageLat;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_NUM_DIMS = 3'd0,
    REG_EXTENT_0 = 3'd1,
    REG_EXTENT_1 = 3'd2,
    REG_EXTENT_2 = 3'd3,
    REG_EXTENT_3 = 3'd4
  } cfg_reg_e;

  // ceil(2^31 / e): exact quotient for any 24-bit dividend and e up to 64
  localparam logic [63:0] P31 = 64'd2147483648;
  localparam logic [RecipW-1:0] RECIP_TBL [MaxExtent+1] = '{
    32'd0,
    32'((P31+0)/1),   32'((P31+1)/2),   32'((P31+2)/3),   32'((P31+3)/4),
    32'((P31+4)/5),   32'((P31+5)/6),   32'((P31+6)/7),   32'((P31+7)/8),
    32'((P31+8)/9),   32'((P31+9)/10),  32'((P31+10)/11), 32'((P31+11)/12),
    32'((P31+12)/13), 32'((P31+13)/14), 32'((P31+14)/15), 32'((P31+15)/16),
    32'((P31+16)/17), 32'((P31+17)/18), 32'((P31+18)/19), 32'((P31+19)/20),
    32'((P31+20)/21), 32'((P31+21)/22), 32'((P31+22)/23), 32'((P31+23)/24),
    32'((P31+24)/25), 32'((P31+25)/26), 32'((P31+26)/27), 32'((P31+27)/28),
    32'((P31+28)/29), 32'((P31+29)/30), 32'((P31+30)/31), 32'((P31+31)/32),
    32'((P31+32)/33), 32'((P31+33)/34), 32'((P31+34)/35), 32'((P31+35)/36),
    32'((P31+36)/37), 32'((P31+37)/38), 32'((P31+38)/39), 32'((P31+39)/40),
    32'((P31+40)/41), 32'((P31+41)/42), 32'((P31+42)/43), 32'((P31+43)/44),
    32'((P31+44)/45), 32'((P31+45)/46), 32'((P31+46)/47), 32'((P31+47)/48),
    32'((P31+48)/49), 32'((P31+49)/50), 32'((P31+50)/51), 32'((P31+51)/52),
    32'((P31+52)/53), 32'((P31+53)/54), 32'((P31+54)/55), 32'((P31+55)/56),
    32'((P31+56)/57), 32'((P31+57)/58), 32'((P31+58)/59), 32'((P31+59)/60),
    32'((P31+60)/61), 32'((P31+61)/62), 32'((P31+62)/63), 32'((P31+63)/64)
  };

  // Word traveling down the pipe
  typedef struct packed {
    logic [SwW-1:0]               src_q;
    logic [SwW-1:0]               dst_q;
    logic [NumDims-1:0][HopW-1:0] hops;
    logic [NumDims-1:0]           plus;
    logic [TotW-1:0]              total;
  } item_t;

  // Per-dimension settings seen by a stage
  typedef struct packed {
    logic              en;
    logic [ExtW-1:0]   ext;
    logic [RecipW-1:0] recip;
  } dim_cfg_t;

  // Zero maps to one, large values saturate
  function automatic logic [ExtW-1:0] eff_extent(input logic [ExtW-1:0] e);
    logic [ExtW-1:0] r;
    r = e;
    if (e == '0) r = ExtW'(1);
    else if (e > ExtW'(MaxExtent)) r = ExtW'(MaxExtent);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/torus_minimal_hop_distance_unit.sv =====
// Torus minimal hop distance: top level, configuration registers and the dimension chain.
// Depends on tmhd_pkg and tmhd_dim_stage.
//
// Usage:
//  - Pulse start with src_switch_i/dst_switch_i; a word is taken at every edge with
//    start high and busy low. busy stays low, so one word can enter every cycle.
//  - Each word yields one result, shown for one cycle with done_o high, after it has
//    passed four dimension stages of three registers each (multiply by reciprocal,
//    multiply back by extent, remainder and ring distance).
//  - Throughput is one word per cycle; results leave in input order.
//  - The receiver cannot stall; results are not held.
//  - Configuration: cfg_we_i with cfg_idx_i / cfg_wdata_i writes one register at
//    once; write only while no word is in flight. Unknown indexes are ignored.
//  - Reset clears the pipe valid bits and loads num_dims 3 and extents 4, 4, 4, 1.
`default_nettype none

module torus_minimal_hop_distance_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cfg_we_i,
  input  wire logic [2:0]                    cfg_idx_i,
  input  wire logic [tmhd_pkg::ExtW-1:0]     cfg_wdata_i,
  input  wire logic [tmhd_pkg::SwW-1:0]      src_switch_i,
  input  wire logic [tmhd_pkg::SwW-1:0]      dst_switch_i,
  output logic                               done_o,
  output logic [tmhd_pkg::HopW-1:0]          hops_d0_o,
  output logic [tmhd_pkg::HopW-1:0]          hops_d1_o,
  output logic [tmhd_pkg::HopW-1:0]          hops_d2_o,
  output logic [tmhd_pkg::HopW-1:0]          hops_d3_o,
  output logic                               plus_d0_o,
  output logic                               plus_d1_o,
  output logic                               plus_d2_o,
  output logic                               plus_d3_o,
  output logic [tmhd_pkg::TotW-1:0]          total_hops_o
);
  import tmhd_pkg::*;

  // Configuration registers
  logic [NdW-1:0]  num_dims_q;
  logic [ExtW-1:0] extent_q [NumDims];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q  <= NdW'(3);
      extent_q[0] <= ExtW'(4);
      extent_q[1] <= ExtW'(4);
      extent_q[2] <= ExtW'(4);
      extent_q[3] <= ExtW'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NUM_DIMS: num_dims_q  <= cfg_wdata_i[NdW-1:0];
        REG_EXTENT_0: extent_q[0] <= cfg_wdata_i;
        REG_EXTENT_1: extent_q[1] <= cfg_wdata_i;
        REG_EXTENT_2: extent_q[2] <= cfg_wdata_i;
        REG_EXTENT_3: extent_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Dimension count saturates at MaxDims
  logic [NdW-1:0] nd;
  assign nd = (num_dims_q > NdW'(MaxDims)) ? NdW'(MaxDims) : num_dims_q;

  assign busy = 1'b0;

  // Entry word
  logic  valid_s [NumDims+1];
  item_t item_s  [NumDims+1];

  always_comb begin
    item_s[0]       = '0;
    item_s[0].src_q = src_switch_i;
    item_s[0].dst_q = dst_switch_i;
  end
  assign valid_s[0] = start & ~busy;

  // Dimension chain
  for (genvar d = 0; d < NumDims; d++) begin : g_dim
    dim_cfg_t        dcfg;
    logic [ExtW-1:0] e;

    assign e          = eff_extent(extent_q[d]);
    assign dcfg.ext   = e;
    assign dcfg.recip = RECIP_TBL[e];
    assign dcfg.en    = (NdW'(d) < nd);

    tmhd_dim_stage #(
      .DIM(d)
    ) u_dim (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (dcfg),
      .valid_i (valid_s[d]),
      .item_i  (item_s[d]),
      .valid_o (valid_s[d+1]),
      .item_o  (item_s[d+1])
    );
  end

  // Result ports come straight from the last stage registers
  assign done_o       = valid_s[NumDims];
  assign hops_d0_o    = item_s[NumDims].hops[0];
  assign hops_d1_o    = item_s[NumDims].hops[1];
  assign hops_d2_o    = item_s[NumDims].hops[2];
  assign hops_d3_o    = item_s[NumDims].hops[3];
  assign plus_d0_o    = item_s[NumDims].plus[0];
  assign plus_d1_o    = item_s[NumDims].plus[1];
  assign plus_d2_o    = item_s[NumDims].plus[2];
  assign plus_d3_o    = item_s[NumDims].plus[3];
  assign total_hops_o = item_s[NumDims].total;

  // Checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##12 done_o)
    else $error("result missing after fixed latency");

  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (total_hops_o == TotW'(hops_d0_o) + TotW'(hops_d1_o)
                              + TotW'(hops_d2_o) + TotW'(hops_d3_o)))
    else $error("total does not match per-dimension hops");

  a_plus0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && plus_d0_o) |-> (hops_d0_o != '0))
    else $error("upward flag with zero hops");

endmodule

`default_nettype wire

// ===== rtl/core/tmhd_dim_stage.sv =====
// One torus dimension: digit split by reciprocal multiply, then ring distance.
// Three register stages; depends on tmhd_pkg.
`default_nettype none

module tmhd_dim_stage #(
  parameter int unsigned DIM = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tmhd_pkg::dim_cfg_t cfg_i,
  input  wire logic              valid_i,
  input  wire tmhd_pkg::item_t   item_i,
  output logic                   valid_o,
  output tmhd_pkg::item_t        item_o
);
  import tmhd_pkg::*;

  // Stage 1: dividend times reciprocal
  logic             v1_q;
  item_t            it1_q;
  logic [ProdW-1:0] ps_d, pd_d, ps_q, pd_q;

  assign ps_d = ProdW'(item_i.src_q) * ProdW'(cfg_i.recip);
  assign pd_d = ProdW'(item_i.dst_q) * ProdW'(cfg_i.recip);

  // Stage 2: quotient and quotient times extent
  logic           v2_q;
  item_t          it2_q;
  logic [SwW-1:0] qs_d, qd_d, qs_q, qd_q;
  logic [SwW-1:0] qes_d, qed_d, qes_q, qed_q;

  assign qs_d  = ps_q[RecipShift +: SwW];
  assign qd_d  = pd_q[RecipShift +: SwW];
  assign qes_d = qs_d * SwW'(cfg_i.ext);
  assign qed_d = qd_d * SwW'(cfg_i.ext);

  // Stage 3: remainders, wrap-aware distance, accumulate
  logic [ExtW-1:0] s, t, up, dn, h;
  logic            p;
  item_t           it3_d, it3_q;
  logic            v3_q;

  always_comb begin
    s = ExtW'(it2_q.src_q - qes_q);
    t = ExtW'(it2_q.dst_q - qed_q);
    if (t > s) begin
      up = t - s;
      dn = s + cfg_i.ext - t;
    end else begin
      up = t + cfg_i.ext - s;
      dn = s - t;
    end
    p = (up <= dn);
    h = p ? up : dn;
    it3_d       = it2_q;
    it3_d.src_q = qs_q;
    it3_d.dst_q = qd_q;
    if (cfg_i.en) begin
      it3_d.hops[DIM] = HopW'(h);
      it3_d.plus[DIM] = p;
      it3_d.total     = it2_q.total + TotW'(h);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    it1_q <= item_i;
    ps_q  <= ps_d;
    pd_q  <= pd_d;
    it2_q <= it1_q;
    qs_q  <= qs_d;
    qd_q  <= qd_d;
    qes_q <= qes_d;
    qed_q <= qed_d;
    it3_q <= it3_d;
  end

  assign valid_o = v3_q;
  assign item_o  = it3_q;

endmodule

`default_nettype wire

// ===== tb/sv/torus_minimal_hop_distance_unit_checker.sv =====
// Checker for the torus hop distance unit: mirrors the config registers, predicts each
// word's hop counts and compares them with the strobed results. Depends on tmhd_pkg.
module torus_minimal_hop_distance_unit_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [tmhd_pkg::ExtW-1:0]     cfg_wdata_i,
  input  logic [tmhd_pkg::SwW-1:0]      src_switch_i,
  input  logic [tmhd_pkg::SwW-1:0]      dst_switch_i,
  input  logic                          done_o,
  input  logic [tmhd_pkg::HopW-1:0]     hops_d0_o,
  input  logic [tmhd_pkg::HopW-1:0]     hops_d1_o,
  input  logic [tmhd_pkg::HopW-1:0]     hops_d2_o,
  input  logic [tmhd_pkg::HopW-1:0]     hops_d3_o,
  input  logic                          plus_d0_o,
  input  logic                          plus_d1_o,
  input  logic                          plus_d2_o,
  input  logic                          plus_d3_o,
  input  logic [tmhd_pkg::TotW-1:0]     total_hops_o,
  output int                            err_cnt,
  output int                            route_pending
);
  import tmhd_pkg::*;

  typedef struct packed {
    logic [3:0][HopW-1:0] hops;
    logic [3:0]           plus;
    logic [TotW-1:0]      total;
  } route_t;

  logic [NdW-1:0]  dims_q;
  logic [ExtW-1:0] ring_q [4];
  route_t          route_q [$];

  // minimal route for one src/dst pair under the current geometry
  function automatic route_t hop_route(logic [SwW-1:0] src, logic [SwW-1:0] dst);
    route_t r;
    int unsigned nd, e, s, t, up, dn, div;
    r = '0;
    div = 1;
    nd = (dims_q > 4) ? 4 : dims_q;
    for (int d = 0; d < 4; d++) begin
      if (d < nd) begin
        e = ring_q[d];
        if (e == 0) e = 1;
        if (e > MaxExtent) e = MaxExtent;
        s = (src / div) % e;
        t = (dst / div) % e;
        if (t > s) begin
          up = t - s; dn = s + e - t;
        end else begin
          up = t + e - s; dn = s - t;
        end
        // equal coordinates fall out as up == e, so the downward zero wins
        if (up <= dn) begin
          r.hops[d] = HopW'(up); r.plus[d] = 1'b1; r.total += TotW'(up);
        end else begin
          r.hops[d] = HopW'(dn); r.total += TotW'(dn);
        end
        div *= e;
      end
    end
    return r;
  endfunction

  assign route_pending = route_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    route_t got, want;
    if (!rst_ni) begin
      dims_q  <= 3;
      ring_q  <= '{7'd4, 7'd4, 7'd4, 7'd1};
      err_cnt <= 0;
      route_q.delete();
    end else begin
      // results first, then the word entering this edge
      if (done_o) begin
        got.hops  = {hops_d3_o, hops_d2_o, hops_d1_o, hops_d0_o};
        got.plus  = {plus_d3_o, plus_d2_o, plus_d1_o, plus_d0_o};
        got.total = total_hops_o;
        if (route_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          err_cnt <= err_cnt + 1;
        end else begin
          want = route_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch hops exp %h act %h plus exp %b act %b total exp %0d act %0d",
                     $realtime, want.hops, got.hops, want.plus, got.plus,
                     want.total, got.total);
            err_cnt <= err_cnt + 1;
          end
        end
      end
      if (start && !busy) route_q.push_back(hop_route(src_switch_i, dst_switch_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NUM_DIMS: dims_q <= cfg_wdata_i[NdW-1:0];
          REG_EXTENT_0: ring_q[0] <= cfg_wdata_i;
          REG_EXTENT_1: ring_q[1] <= cfg_wdata_i;
          REG_EXTENT_2: ring_q[2] <= cfg_wdata_i;
          REG_EXTENT_3: ring_q[3] <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/sv/torus_minimal_hop_distance_unit_test.sv =====
// Stimulus and verdict for the torus hop distance unit: geometry phases, directed and
// random switch pairs. Depends on tmhd_pkg, the unit and its checker.
module torus_minimal_hop_distance_unit_test;
  import tmhd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [ExtW-1:0] cfg_wdata_i = '0;
  logic [SwW-1:0] src_switch_i = '0, dst_switch_i = '0;
  logic done_o;
  logic [HopW-1:0] hops_d0_o, hops_d1_o, hops_d2_o, hops_d3_o;
  logic plus_d0_o, plus_d1_o, plus_d2_o, plus_d3_o;
  logic [TotW-1:0] total_hops_o;
  int err_cnt, route_pending;
  int quiet_cycles = 0;
  bit calm;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  torus_minimal_hop_distance_unit dut (.*);
  torus_minimal_hop_distance_unit_checker chk (.*);

  // watchdog: cycles with no word taken and no result out
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // write enable is left high; the caller drops it after the last write
  task automatic cfg_write(cfg_reg_e idx, logic [ExtW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(int nd, int e0, int e1, int e2, int e3);
    start <= 1'b0;
    while (route_pending != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
    cfg_write(REG_NUM_DIMS, ExtW'(nd));
    cfg_write(REG_EXTENT_0, ExtW'(e0));
    cfg_write(REG_EXTENT_1, ExtW'(e1));
    cfg_write(REG_EXTENT_2, ExtW'(e2));
    cfg_write(REG_EXTENT_3, ExtW'(e3));
    cfg_we_i <= 1'b0;
  endtask

  // one word, with random gaps unless in a calm stretch; start stays high afterwards
  task automatic send_pair(logic [SwW-1:0] s, logic [SwW-1:0] t);
    while (!calm && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    src_switch_i <= s;
    dst_switch_i <= t;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic random_pairs(int n);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 2) && (i < n / 2 + 20);
      if ($urandom_range(3) == 0) send_pair(SwW'($urandom), SwW'($urandom));
      else send_pair(SwW'($urandom_range(4095)), SwW'($urandom_range(4095)));
    end
    calm = 1'b0;
  endtask

  initial begin
    calm = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset geometry: 4x4x4, extremes and ties
    send_pair(0, 0);
    send_pair(0, 2);
    send_pair(0, 63);
    send_pair(24'hFFFFFF, 0);
    send_pair(24'hAAAAAA, 24'h555555);
    send_pair(1, 3);
    random_pairs(40);
    // max extents and dims, even rings give ties
    set_geometry(4, 64, 64, 64, 64);
    send_pair(0, 32);
    send_pair(32, 0);
    send_pair(24'hFFFFFF, 24'h000000);
    send_pair(24'h820820, 24'h000000);
    random_pairs(80);
    // zero count, oversized count, zero and oversized extents
    set_geometry(0, 5, 5, 5, 5);
    send_pair(1, 3);
    send_pair(24'hFFFFFF, 24'h123456);
    set_geometry(7, 0, 127, 65, 3);
    send_pair(0, 24'hFFFFFF);
    send_pair(24'hFFFFFF, 7);
    random_pairs(60);
    // one dimension, odd ring
    set_geometry(1, 7, 1, 1, 1);
    send_pair(0, 3);
    send_pair(0, 4);
    random_pairs(60);
    // mixed odd/even rings
    set_geometry(2, 1, 2, 64, 64);
    random_pairs(60);
    set_geometry(4, 3, 5, 6, 33);
    random_pairs(70);
    set_geometry(3, 64, 63, 2, 9);
    random_pairs(60);
    start <= 1'b0;
    while (route_pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (err_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/tmhd_pkg.sv
rtl/core/tmhd_dim_stage.sv
rtl/core/torus_minimal_hop_distance_unit.sv
tb/sv/torus_minimal_hop_distance_unit_checker.sv
tb/sv/torus_minimal_hop_distance_unit_test.sv
